### src/tga_rle_pixel_decoder_top_macros.svh
// Assertion macros shared by the TGA run-length decoder RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define TGARLE_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TGARLE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tgarle_pkg.sv
// Shared types, constants and helper functions of the TGA run-length decoder.
// No dependencies; every other file but the macro header refers to it by scoped names.
package tgarle_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned TOTAL_W    = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic               RST_PIXEL_DEPTH_MODE = 1'b0;
  localparam logic               RST_RLE_MODE         = 1'b1;
  localparam logic [TOTAL_W-1:0] RST_PIXEL_TOTAL      = 32'd1;

  // Packet header: bit 7 marks a repeated pixel, the low bits hold count - 1.
  localparam int unsigned HDR_REPEAT_BIT = 7;

  // Index of the final byte of a pixel for each depth.
  localparam logic [1:0] LAST_IDX_24 = 2'd2;
  localparam logic [1:0] LAST_IDX_32 = 2'd3;

  // Reciprocal of three scaled by 2**11, exact in floor for sums up to 765.
  localparam logic [20:0] RECIP3     = 21'd683;
  localparam int unsigned RECIP3_SHR = 11;

  typedef struct packed {
    logic               pixel_depth_mode;
    logic               rle_mode;
    logic [TOTAL_W-1:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
  } stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [BYTE_W-1:0]  alpha;
    logic [COUNT_W-1:0] repeat_count;
    logic               last;
    logic               overrun;
  } pixel_t;

  // Truncated mean of three channels without a divider.
  function automatic logic [BYTE_W-1:0] avg3(input logic [BYTE_W-1:0] r,
                                             input logic [BYTE_W-1:0] g,
                                             input logic [BYTE_W-1:0] b);
    logic [9:0]  sum;
    logic [20:0] prod;
    sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
    prod = {11'd0, sum} * RECIP3;
    return prod[RECIP3_SHR +: BYTE_W];
  endfunction

endpackage

### src/tgarle_ifs.sv
// Valid/ready channel interfaces of the TGA run-length decoder.
// Depends on tgarle_pkg for field widths.
interface tgarle_byte_if;
  logic                          valid;
  logic                          ready;
  logic [tgarle_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tgarle_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [tgarle_pkg::BYTE_W-1:0]  red;
  logic [tgarle_pkg::BYTE_W-1:0]  green;
  logic [tgarle_pkg::BYTE_W-1:0]  blue;
  logic [tgarle_pkg::BYTE_W-1:0]  alpha;
  logic [tgarle_pkg::COUNT_W-1:0] repeat_count;
  logic                           last;
  logic                           overrun;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_count, output last, output overrun, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_count, input last, input overrun, output ready);
endinterface

### src/tgarle_in_reg.sv
// Input register of the TGA run-length decoder: captures one data beat.
// Depends on tgarle_pkg and the byte channel interface.
module tgarle_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  tgarle_byte_if.sink          data_in,
  input  logic                 take,
  output tgarle_pkg::stage_t   stage
);

  logic                          valid;
  logic [tgarle_pkg::BYTE_W-1:0] data_byte;

  assign data_in.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (data_in.ready) begin
      valid <= data_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_in.valid && data_in.ready) begin
      data_byte <= data_in.data_byte;
    end
  end

  assign stage.valid     = valid;
  assign stage.data_byte = data_byte;

endmodule

### src/tgarle_decode.sv
// Packet and pixel decoder: holds the parse state and turns a byte into a result.
// Depends on tgarle_pkg and the assertion macro header.
`include "tga_rle_pixel_decoder_top_macros.svh"

module tgarle_decode (
  input  logic                clk,
  input  logic                rst,
  input  tgarle_pkg::cfg_t    cfg,
  input  tgarle_pkg::stage_t  stage,
  input  logic                out_free,
  output logic                take,
  output logic                res_load,
  output tgarle_pkg::pixel_t  res
);

  logic                                expect_header, expect_header_next;
  logic [1:0]                          byte_in_pixel, byte_in_pixel_next;
  logic [tgarle_pkg::COUNT_W-1:0]      pixels_left, pixels_left_next;
  logic                                packet_is_repeat, packet_is_repeat_next;
  logic [tgarle_pkg::BYTE_W-1:0]       pixel_bytes [3];
  logic [tgarle_pkg::BYTE_W-1:0]       pixel_bytes_next [3];
  logic [tgarle_pkg::TOTAL_W-1:0]      pixels_done, pixels_done_next;

  logic [1:0]                          last_index;
  logic                                hdr_step, byte_step, produce;
  logic [tgarle_pkg::COUNT_W-1:0]      in_packet, count, count_out;
  logic [tgarle_pkg::TOTAL_W-1:0]      rem, count_wide, done_sum;
  logic                                clip, last, over;
  logic [tgarle_pkg::BYTE_W-1:0]       b;

  assign b          = stage.data_byte;
  assign last_index = cfg.pixel_depth_mode ? tgarle_pkg::LAST_IDX_32 : tgarle_pkg::LAST_IDX_24;
  assign hdr_step   = cfg.rle_mode && expect_header;
  assign byte_step  = !hdr_step && (byte_in_pixel < last_index);
  assign produce    = !hdr_step && !byte_step;

  // A byte leaves the input register unless it makes a result that has nowhere to go.
  assign take     = stage.valid && (!produce || out_free);
  assign res_load = take && produce;

  // Count and clipping against the pixel total.
  assign in_packet  = (pixels_left == '0) ? 8'd1 : pixels_left;
  assign count      = (cfg.rle_mode && packet_is_repeat) ? in_packet : 8'd1;
  assign count_wide = {{(tgarle_pkg::TOTAL_W-tgarle_pkg::COUNT_W){1'b0}}, count};
  assign rem        = (pixels_done < cfg.pixel_total) ? (cfg.pixel_total - pixels_done)
                                                      : 32'd1;
  assign clip       = count_wide > rem;
  assign last       = !(count_wide < rem);
  assign count_out  = clip ? rem[tgarle_pkg::COUNT_W-1:0] : count;
  assign over       = cfg.rle_mode &&
                      (clip || (last && !packet_is_repeat && (in_packet > 8'd1)));
  assign done_sum   = pixels_done + count_wide;

  assign res.red          = pixel_bytes[2];
  assign res.green        = pixel_bytes[1];
  assign res.blue         = pixel_bytes[0];
  assign res.alpha        = (cfg.pixel_depth_mode && (byte_in_pixel == tgarle_pkg::LAST_IDX_32))
                            ? b : tgarle_pkg::avg3(pixel_bytes[2], pixel_bytes[1], pixel_bytes[0]);
  assign res.repeat_count = count_out;
  assign res.last         = last;
  assign res.overrun      = over;

  always_comb begin
    expect_header_next    = expect_header;
    byte_in_pixel_next    = byte_in_pixel;
    pixels_left_next      = pixels_left;
    packet_is_repeat_next = packet_is_repeat;
    pixel_bytes_next      = pixel_bytes;
    pixels_done_next      = pixels_done;
    if (take) begin
      priority if (hdr_step) begin
        packet_is_repeat_next = b[tgarle_pkg::HDR_REPEAT_BIT];
        pixels_left_next      = {1'b0, b[tgarle_pkg::HDR_REPEAT_BIT-1:0]} + 8'd1;
        expect_header_next    = 1'b0;
        byte_in_pixel_next    = 2'd0;
      end else if (byte_step) begin
        pixel_bytes_next[byte_in_pixel] = b;
        byte_in_pixel_next              = byte_in_pixel + 2'd1;
      end else if (last) begin
        // Image complete: start over and wait for the next packet header.
        pixels_done_next      = '0;
        expect_header_next    = 1'b1;
        pixels_left_next      = '0;
        packet_is_repeat_next = 1'b0;
        byte_in_pixel_next    = 2'd0;
      end else begin
        byte_in_pixel_next = 2'd0;
        pixels_done_next   = done_sum;
        if (cfg.rle_mode) begin
          if (packet_is_repeat || (in_packet <= 8'd1)) begin
            pixels_left_next   = '0;
            expect_header_next = 1'b1;
          end else begin
            pixels_left_next = in_packet - 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header    <= 1'b1;
      byte_in_pixel    <= 2'd0;
      pixels_left      <= '0;
      packet_is_repeat <= 1'b0;
      pixel_bytes      <= '{default: '0};
      pixels_done      <= '0;
    end else begin
      expect_header    <= expect_header_next;
      byte_in_pixel    <= byte_in_pixel_next;
      pixels_left      <= pixels_left_next;
      packet_is_repeat <= packet_is_repeat_next;
      pixel_bytes      <= pixel_bytes_next;
      pixels_done      <= pixels_done_next;
    end
  end

  `TGARLE_CHECK(a_overrun_only_on_last, res_load && res.overrun, res.last,
                "overrun flagged on a result that is not last")
  `TGARLE_CHECK(a_count_in_range, res_load,
                (res.repeat_count != 8'd0) && (res.repeat_count <= 8'd128),
                "repeat count outside 1..128")
  `TGARLE_CHECK(a_raw_no_overrun, res_load && !cfg.rle_mode, !res.overrun,
                "overrun flagged in raw mode")
  `TGARLE_CHECK_NEXT(a_restart_after_last, res_load && res.last,
                     (pixels_done == '0) && expect_header && (byte_in_pixel == 2'd0),
                     "decoder did not restart after the last pixel")

endmodule

### src/tgarle_out_reg.sv
// Result register of the TGA run-length decoder: holds one pixel beat for the sink.
// Depends on tgarle_pkg and the pixel channel interface.
module tgarle_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tgarle_pkg::pixel_t  res,
  output logic                free,
  tgarle_pixel_if.source      pixel_out
);

  logic               valid;
  tgarle_pkg::pixel_t data;

  assign free = !valid || pixel_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data <= res;
    end
  end

  assign pixel_out.valid        = valid;
  assign pixel_out.red          = data.red;
  assign pixel_out.green        = data.green;
  assign pixel_out.blue         = data.blue;
  assign pixel_out.alpha        = data.alpha;
  assign pixel_out.repeat_count = data.repeat_count;
  assign pixel_out.last         = data.last;
  assign pixel_out.overrun      = data.overrun;

endmodule

### src/tga_rle_pixel_decoder_top.sv
// Top level of the TGA run-length pixel decoder.
// Depends on tgarle_pkg, the channel interfaces and the three stage modules.
//
// This block decodes the pixel-data section of a TGA image, one byte per beat on
// data_in, and sends decoded pixels on pixel_out as RGBA with a repeat count.
// It accepts one byte every clock cycle for as long as pixel_out keeps up; a byte
// that completes a pixel is held first in the input register and then in the
// result register, from which its result is sent on pixel_out. Bytes that only
// open a packet or fill a pixel produce nothing. Throughput is set by the single
// pass of decode logic between those two registers, with the 32-bit remaining
// count subtraction and compare as its longest path. While a result waits in the
// output register, the next byte is still taken and can be decoded as long as it
// does not itself finish a pixel.
// Configuration: index 0 selects 24-bit BGR (0) or 32-bit BGRA (1) pixels, index 1
// selects raw (0) or run-length (1) data, and index 2 sets the image's pixel total.
// Writes to other indexes are ignored. Write only while the block is idle.
// In 24-bit mode alpha is the truncated mean of red, green and blue. A run that
// would pass the pixel total is cut short and flagged with overrun; the result
// that reaches the total carries last, after which the decoder drops the rest of
// the packet and expects the header of the next image at once.
// Reset is synchronous and active high; no clearing pass is needed after it.
module tga_rle_pixel_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  tgarle_byte_if.sink                       data_in,
  tgarle_pixel_if.source                    pixel_out,
  input  logic                              cfg_we,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic                               pixel_depth_mode;
  logic                               rle_mode;
  logic [tgarle_pkg::TOTAL_W-1:0]     pixel_total;
  tgarle_pkg::cfg_t                   cfg;

  // Handshake between the stages.
  tgarle_pkg::stage_t                 stage;
  tgarle_pkg::pixel_t                 res;
  logic                               take;
  logic                               res_load;
  logic                               out_free;

  // Register writes go straight in; there is no read-back path.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth_mode <= tgarle_pkg::RST_PIXEL_DEPTH_MODE;
      rle_mode         <= tgarle_pkg::RST_RLE_MODE;
      pixel_total      <= tgarle_pkg::RST_PIXEL_TOTAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgarle_pkg::CFG_PIXEL_DEPTH_MODE: pixel_depth_mode <= cfg_data[0];
        tgarle_pkg::CFG_RLE_MODE:         rle_mode         <= cfg_data[0];
        tgarle_pkg::CFG_PIXEL_TOTAL:      pixel_total      <= cfg_data[tgarle_pkg::TOTAL_W-1:0];
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  assign cfg.pixel_depth_mode = pixel_depth_mode;
  assign cfg.rle_mode         = rle_mode;
  assign cfg.pixel_total      = pixel_total;

  // The input register holds one byte; it frees up whenever the decoder takes it.
  tgarle_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .data_in (data_in),
    .take    (take),
    .stage   (stage)
  );

  // The decoder owns the packet, pixel and image counters and builds each result.
  tgarle_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .stage    (stage),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  // The result register holds each pixel beat and passes the sink's ready back.
  tgarle_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .free      (out_free),
    .pixel_out (pixel_out)
  );

endmodule

### test/tga_rle_pixel_decoder_checker.sv
`timescale 1ns / 100ps
// Checker for the TGA run-length pixel decoder: watches both channels and the
// configuration port, predicts each pixel beat and compares it with the block.
// Depends on tgarle_pkg and the channel interfaces.
module tga_rle_pixel_decoder_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  tgarle_byte_if                                data_in,
  tgarle_pixel_if                               pixel_out,
  input  logic                                  cfg_we,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                    failures,
  output int                                    pending
);

  localparam int REPORT_LIMIT = 10;

  // Configuration copy.
  logic                           depth_32     = tgarle_pkg::RST_PIXEL_DEPTH_MODE;
  logic                           rle_on       = tgarle_pkg::RST_RLE_MODE;
  logic [tgarle_pkg::TOTAL_W-1:0] image_pixels = tgarle_pkg::RST_PIXEL_TOTAL;

  // Decoder state copy.
  logic                           awaiting_header = 1'b1;
  logic [1:0]                     byte_idx        = '0;
  logic [7:0]                     packet_left     = '0;
  logic                           run_packet      = 1'b0;
  logic [tgarle_pkg::BYTE_W-1:0]  stored_bytes [3] = '{default: '0};
  logic [tgarle_pkg::TOTAL_W-1:0] pixels_done     = '0;

  tgarle_pkg::pixel_t expected_pixels [$];
  int                 mismatches = 0;

  function automatic void start_new_image();
    pixels_done     = '0;
    awaiting_header = 1'b1;
    packet_left     = '0;
    run_packet      = 1'b0;
    byte_idx        = '0;
  endfunction

  // Returns 1 when the byte completes a pixel, with the decoded pixel in px.
  function automatic bit decode_byte(input logic [tgarle_pkg::BYTE_W-1:0] b,
                                     output tgarle_pkg::pixel_t px);
    logic [1:0]  final_idx;
    logic [9:0]  sum;
    logic [31:0] in_packet, count, remaining;
    bit          is_last, clipped;
    final_idx = depth_32 ? tgarle_pkg::LAST_IDX_32 : tgarle_pkg::LAST_IDX_24;
    px = '0;
    if (rle_on && awaiting_header) begin
      run_packet      = b[tgarle_pkg::HDR_REPEAT_BIT];
      packet_left     = {1'b0, b[6:0]} + 8'd1;
      awaiting_header = 1'b0;
      byte_idx        = '0;
      return 1'b0;
    end
    if (byte_idx < final_idx) begin
      if (byte_idx < 2'd3) stored_bytes[byte_idx] = b;
      byte_idx++;
      return 1'b0;
    end
    px.red   = stored_bytes[2];
    px.green = stored_bytes[1];
    px.blue  = stored_bytes[0];
    sum = {2'b00, px.red} + {2'b00, px.green} + {2'b00, px.blue};
    px.alpha = (depth_32 && byte_idx == 2'd3) ? b : tgarle_pkg::BYTE_W'(sum / 10'd3);
    byte_idx = '0;

    in_packet = (packet_left == 0) ? 32'd1 : 32'(packet_left);
    count     = (rle_on && run_packet) ? in_packet : 32'd1;
    remaining = (pixels_done < image_pixels) ? image_pixels - pixels_done : 32'd1;
    clipped   = 1'b0;
    if (count > remaining) begin
      count   = remaining;
      clipped = 1'b1;
    end
    is_last = (count == remaining);
    // Literal pixels left over in the packet also count as overrun.
    if (rle_on && is_last && !run_packet && in_packet > 1) clipped = 1'b1;
    if (!rle_on) clipped = 1'b0;

    if (is_last) begin
      start_new_image();
    end else begin
      pixels_done += count;
      if (rle_on) begin
        if (run_packet || in_packet <= 1) begin
          packet_left     = '0;
          awaiting_header = 1'b1;
        end else begin
          packet_left = 8'(in_packet - 1);
        end
      end
    end
    px.repeat_count = tgarle_pkg::COUNT_W'(count);
    px.last         = is_last;
    px.overrun      = clipped;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    tgarle_pkg::pixel_t predicted, observed, wanted;
    if (rst) begin
      depth_32     = tgarle_pkg::RST_PIXEL_DEPTH_MODE;
      rle_on       = tgarle_pkg::RST_RLE_MODE;
      image_pixels = tgarle_pkg::RST_PIXEL_TOTAL;
      foreach (stored_bytes[i]) stored_bytes[i] = '0;
      start_new_image();
      expected_pixels.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tgarle_pkg::CFG_PIXEL_DEPTH_MODE: depth_32     = cfg_data[0];
          tgarle_pkg::CFG_RLE_MODE:         rle_on       = cfg_data[0];
          tgarle_pkg::CFG_PIXEL_TOTAL:      image_pixels = cfg_data[tgarle_pkg::TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (data_in.valid && data_in.ready) begin
        if (decode_byte(data_in.data_byte, predicted)) expected_pixels.push_back(predicted);
      end
      if (pixel_out.valid && pixel_out.ready) begin
        observed.red          = pixel_out.red;
        observed.green        = pixel_out.green;
        observed.blue         = pixel_out.blue;
        observed.alpha        = pixel_out.alpha;
        observed.repeat_count = pixel_out.repeat_count;
        observed.last         = pixel_out.last;
        observed.overrun      = pixel_out.overrun;
        if (expected_pixels.size() == 0) begin
          failures++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: pixel beat with none outstanding", $realtime);
            $display("  got  rgba=%h %h %h %h n=%0d last=%b over=%b",
                     observed.red, observed.green, observed.blue, observed.alpha,
                     observed.repeat_count, observed.last, observed.overrun);
          end
        end else begin
          wanted = expected_pixels.pop_front();
          if (observed.red !== wanted.red || observed.green !== wanted.green ||
              observed.blue !== wanted.blue || observed.alpha !== wanted.alpha ||
              observed.repeat_count !== wanted.repeat_count ||
              observed.last !== wanted.last || observed.overrun !== wanted.overrun) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: pixel mismatch", $realtime);
              $display("  want rgba=%h %h %h %h n=%0d last=%b over=%b",
                       wanted.red, wanted.green, wanted.blue, wanted.alpha,
                       wanted.repeat_count, wanted.last, wanted.overrun);
              $display("  got  rgba=%h %h %h %h n=%0d last=%b over=%b",
                       observed.red, observed.green, observed.blue, observed.alpha,
                       observed.repeat_count, observed.last, observed.overrun);
            end
          end
        end
      end
      pending = expected_pixels.size();
    end
  end

endmodule

### test/tga_rle_pixel_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the TGA run-length pixel decoder: clock, reset, byte stimulus,
// configuration writes and the verdict. Depends on tgarle_pkg, the interfaces and the checker.
module tga_rle_pixel_decoder_top_tb;

  localparam logic [tgarle_pkg::TOTAL_W-1:0] MAX_PIXELS = 32'd4294836225;
  // Drain pause; covers a final byte still in the input or result register, with margin.
  localparam int DRAIN_CYCLES    = 4;
  localparam int HOLD_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_BYTES    = 750;
  localparam int IMAGE_BYTE_CAP  = 80;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data;

  tgarle_byte_if  byte_ch ();
  tgarle_pixel_if pixel_ch ();

  int failures;
  int pending;

  // Stimulus bookkeeping: what the decoder is currently set to, and how hard
  // each side idles in the current phase.
  logic                           cur_depth_32;
  logic                           cur_rle;
  logic [tgarle_pkg::TOTAL_W-1:0] cur_total;
  int                             send_idle_pct;
  int                             recv_stall_pct;
  int                             sent_count;

  // Long receiver hold-off: the stimulus toggles hold_req, the receiver
  // process notices the change and counts the stall itself.
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  tga_rle_pixel_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .data_in   (byte_ch),
    .pixel_out (pixel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_pixel_decoder_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .data_in   (byte_ch),
    .pixel_out (pixel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stalls at the phase's rate, or holds off completely for a long
  // stretch after a request, so that the decoder backs up into its input.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      pixel_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pixel_ch.ready <= 1'b0;
    end else begin
      pixel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any stretch with no beat on either channel longer than the
  // limit means the decoder or the bench has hung.
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one byte, with random idle cycles before it, and returns at the
  // edge at which the decoder takes it. Valid stays high on return so that
  // back-to-back bytes need no gap.
  task automatic send_byte(input logic [tgarle_pkg::BYTE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= value;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // One pixel of random bytes at the depth currently set.
  task automatic send_pixel();
    repeat (cur_depth_32 ? 4 : 3) send_byte(tgarle_pkg::BYTE_W'($urandom_range(255)));
  endtask

  // Stops offering bytes and waits until every predicted pixel has come out.
  // A header or filler byte never shows up as a pixel, so a short pause on
  // either side covers a byte that is still inside the pipeline.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle, once the decoder is idle.
  task automatic apply_settings(input logic depth_32, input logic rle,
                                input logic [tgarle_pkg::TOTAL_W-1:0] total);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= tgarle_pkg::CFG_PIXEL_DEPTH_MODE;
    cfg_data  <= tgarle_pkg::CFG_DATA_W'(depth_32);
    @(posedge clk);
    cfg_index <= tgarle_pkg::CFG_RLE_MODE;
    cfg_data  <= tgarle_pkg::CFG_DATA_W'(rle);
    @(posedge clk);
    cfg_index <= tgarle_pkg::CFG_PIXEL_TOTAL;
    cfg_data  <= total;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_depth_32 = depth_32;
    cur_rle      = rle;
    cur_total    = total;
  endtask

  // One random image: fresh settings, then mostly well-formed packets (or raw
  // pixels) covering the pixel total, with a little noise mixed in. A huge
  // total is capped by bytes, which leaves the image open for the next one.
  task automatic random_image();
    logic                           depth_32, rle, run_bit;
    logic [tgarle_pkg::TOTAL_W-1:0] total;
    int                             pick, covered, image_start, n;
    depth_32 = 1'($urandom_range(1));
    rle      = ($urandom_range(3) != 0);
    pick     = $urandom_range(19);
    if (pick == 0)
      total = MAX_PIXELS;
    else if (pick == 1)
      total = 1;
    else if (pick == 2)
      total = $urandom_range(1, 4);
    else
      total = $urandom_range(2, 24);
    apply_settings(depth_32, rle, total);

    covered     = 0;
    image_start = sent_count;
    while (covered < total && sent_count - image_start < IMAGE_BYTE_CAP) begin
      if (!rle) begin
        send_pixel();
        covered++;
      end else if ($urandom_range(19) == 0) begin
        // A stray byte knocks the packet framing out of step.
        send_byte(tgarle_pkg::BYTE_W'($urandom_range(255)));
      end else begin
        run_bit = 1'($urandom_range(1));
        if (run_bit && $urandom_range(6) == 0)
          n = $urandom_range(1, 128);
        else
          n = $urandom_range(1, 6);
        send_byte({run_bit, 7'(n - 1)});
        if (run_bit) begin
          send_pixel();
        end else begin
          repeat (n) send_pixel();
        end
        covered += n;
      end
    end
    // Sometimes a cut-off tail of random bytes.
    if ($urandom_range(6) == 0)
      repeat ($urandom_range(1, 5)) send_byte(tgarle_pkg::BYTE_W'($urandom_range(255)));
  endtask

  initial begin
    int phase_goal;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    send_idle_pct     = 0;
    recv_stall_pct    <= 0;
    sent_count        = 0;
    cur_depth_32      = tgarle_pkg::RST_PIXEL_DEPTH_MODE;
    cur_rle           = tgarle_pkg::RST_RLE_MODE;
    cur_total         = tgarle_pkg::RST_PIXEL_TOTAL;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // A 32-bit run of the longest length, 128 copies.
    apply_settings(1'b1, 1'b1, 32'd200);
    send_byte(8'hFF);
    repeat (4) send_byte(8'h00);
    // The total is lowered below the pixels already done: the next pixel is
    // a single literal copy and closes the image. The header is the all-zero byte.
    apply_settings(1'b1, 1'b1, 32'd100);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);
    // A 24-bit literal packet of three pixels where two are wanted: the second
    // one is last and flags the unused literal as overrun.
    apply_settings(1'b0, 1'b1, 32'd2);
    send_byte(8'h02);
    repeat (3) send_byte(8'hFF);
    repeat (3) send_byte(8'h00);
    // Smallest total: a run of six clipped to one.
    apply_settings(1'b0, 1'b1, 32'd1);
    send_byte(8'h85);
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(8'h30);
    // Raw bytes with the MAX_PIXELS total; depth drops from 32 to 24 bits after
    // three bytes of a pixel, so the fourth byte finishes it with averaged alpha.
    apply_settings(1'b1, 1'b0, MAX_PIXELS);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    apply_settings(1'b0, 1'b0, MAX_PIXELS);
    send_byte(8'h44);

    // Random part in four idling phases: none, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 83; end
        default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
      endcase
      phase_goal = sent_count + RANDOM_BYTES / 4;
      if (phase == 0) begin
        // Back-pressure: the receiver stops for a long stretch while raw
        // 24-bit pixels keep coming, so the decoder must stall its input.
        apply_settings(1'b0, 1'b0, MAX_PIXELS);
        hold_req <= ~hold_req;
        repeat (40) send_byte(tgarle_pkg::BYTE_W'($urandom_range(255)));
      end
      while (sent_count < phase_goal) random_image();
    end

    // Drain, then give the verdict.
    settle();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
